// ----- design/ptwc_pkg.sv -----
// Shared types, constants and command bundle of the periodic task window checker.
package ptwc_pkg;

    localparam int REG_W         = 20;
    localparam int IN_TIME_W     = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [REG_W-1:0] PERIOD_RST = 20'd1000000;
    localparam logic [REG_W-1:0] RIGHT_RST  = 20'd1000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT    = 2'd3;

    typedef struct packed {
        logic [IN_TIME_W-1:0] current_time;
        logic [IN_TIME_W-1:0] alt_deadline;
        logic                 mode;
        logic [IN_TIME_W-1:0] record_time;
    } t_in_req;

    typedef struct packed {
        logic             ready_res;
        logic             on_time;
        logic             on_time_alt;
        logic             missed;
        logic             finished;
        logic             ran_this_period;
        logic [REG_W-1:0] slack;
    } t_out_res;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_start_t;
        logic div_start_l;
        logic div_step;
        logic calc1;
        logic calc2;
        logic calc3;
        logic calc4;
        logic store;
    } t_cmd;

endpackage

// ----- design/ptwc_datapath.sv -----
// Datapath: config registers, stored execution time, serial remainder unit, result math.
module ptwc_datapath
    import ptwc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  t_in_req              i_in_data,
    input  t_cmd                 i_cmd,
    output t_out_res             o_out_data
);

    // time width actually carried: inputs are 32 bits
    localparam int TW = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    // unwrapped working width for sums of a time and two register values
    localparam int WW = ((TW > REG_W) ? TW : REG_W) + 2;

    logic [REG_W-1:0] r_period, r_duration, r_left, r_right;
    logic [TW-1:0]    r_last;
    logic [TW-1:0]    r_t, r_alt, r_lw;
    logic [TW-1:0]    r_dvd;
    logic [REG_W-1:0] r_rem, r_rt;
    logic [TW-1:0]    r_p, r_lbase;
    logic             r_at_start, r_lmod0;
    logic [WW-1:0]    r_win_lo, r_win_hi, r_fin_t, r_miss_bnd, r_prev_lo, r_prev_hi;
    logic [WW-1:0]    r_from, r_room;
    logic             r_sl_zero;
    logic             r_ready, r_on_time, r_on_alt, r_missed, r_finished, r_ran;
    t_out_res         r_out;

    logic [REG_W-1:0] per_eff;
    logic [REG_W:0]   rem_sh;
    logic [REG_W:0]   rem_sub;
    logic [WW-1:0]    t_w, alt_w, lw_w, p_w, dur_w, left_w, right_w, per_w;
    logic [WW-1:0]    from_c;
    logic             in_win_last;
    logic [WW-1:0]    slack_diff;

    assign per_eff = (r_period == '0) ? REG_W'(1) : r_period;

    // one restoring remainder step
    assign rem_sh  = {r_rem, r_dvd[TW-1]};
    assign rem_sub = rem_sh - {1'b0, per_eff};

    assign t_w     = WW'(r_t);
    assign alt_w   = WW'(r_alt);
    assign lw_w    = WW'(r_lw);
    assign p_w     = WW'(r_p);
    assign dur_w   = WW'(r_duration);
    assign left_w  = WW'(r_left);
    assign right_w = WW'(r_right);
    assign per_w   = WW'(per_eff);

    assign from_c      = (t_w > r_win_lo) ? t_w : r_win_lo;
    assign in_win_last = (lw_w > r_win_lo) && (lw_w <= r_win_hi);
    assign slack_diff  = r_room - dur_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RST;
            r_duration <= '0;
            r_left     <= '0;
            r_right    <= RIGHT_RST;
            r_last     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERIOD:   r_period   <= i_cfg_data;
                    CFG_DURATION: r_duration <= i_cfg_data;
                    CFG_LEFT:     r_left     <= i_cfg_data;
                    CFG_RIGHT:    r_right    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && i_in_data.mode) begin
                r_last <= i_in_data.record_time[TW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t   <= i_in_data.current_time[TW-1:0];
            r_alt <= i_in_data.alt_deadline[TW-1:0];
            r_lw  <= r_last;    // results use the value before the record
        end

        if (i_cmd.div_start_t) begin
            r_dvd <= i_in_data.current_time[TW-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_start_l) begin
            r_dvd <= r_lw;
            r_rem <= '0;
            r_rt  <= r_rem;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= rem_sub[REG_W] ? rem_sh[REG_W-1:0] : rem_sub[REG_W-1:0];
        end

        if (i_cmd.calc1) begin
            r_p        <= r_t - TW'(r_rt);
            r_lbase    <= r_lw - TW'(r_rem);
            r_at_start <= (r_rt == '0);
            r_lmod0    <= (r_rem == '0);
        end

        if (i_cmd.calc2) begin
            r_win_lo   <= p_w + left_w;
            r_win_hi   <= p_w + right_w;
            r_fin_t    <= t_w + dur_w;
            r_miss_bnd <= r_lmod0 ? (lw_w + right_w) : (WW'(r_lbase) + right_w + per_w);
            // only used at a period start with t > 0, where p >= period
            r_prev_lo  <= p_w + left_w - per_w;
            r_prev_hi  <= p_w + right_w - per_w;
        end

        if (i_cmd.calc3) begin
            r_from <= from_c;
            if (r_at_start) begin
                r_ready <= (r_left == '0);
            end else if (in_win_last) begin
                r_ready <= 1'b0;
            end else begin
                r_ready <= (t_w >= r_win_lo) && (t_w < r_win_hi);
            end
            if (!r_at_start && (lw_w > r_win_lo)) begin
                r_on_time <= 1'b1;
                r_on_alt  <= 1'b1;
            end else begin
                r_on_time <= (r_fin_t <= r_win_hi);
                r_on_alt  <= (r_fin_t <= alt_w);
            end
            r_missed <= (t_w > r_miss_bnd);
            r_ran    <= (lw_w > p_w);
            if (r_t == '0) begin
                r_finished <= 1'b0;
            end else if (r_at_start) begin
                r_finished <= (lw_w <= r_prev_hi) && (lw_w > r_prev_lo);
            end else begin
                r_finished <= (lw_w > p_w);
            end
        end

        if (i_cmd.calc4) begin
            r_room    <= r_win_hi - r_from;
            r_sl_zero <= (r_from >= r_win_hi);
        end

        if (i_cmd.store) begin
            r_out.ready_res       <= r_ready;
            r_out.on_time         <= r_on_time;
            r_out.on_time_alt     <= r_on_alt;
            r_out.missed          <= r_missed;
            r_out.finished        <= r_finished;
            r_out.ran_this_period <= r_ran;
            r_out.slack           <= (r_sl_zero || (r_room <= dur_w)) ? '0
                                                                       : slack_diff[REG_W-1:0];
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- design/ptwc_ctrl.sv -----
// Controller: sequences the two remainder passes, the result steps and the handshakes.
module ptwc_ctrl
    import ptwc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam int TW = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam int CW = $clog2(TW);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_T, S_SWAP, S_DIV_L, S_CALC1, S_CALC2, S_CALC3, S_CALC4, S_STORE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          in_acc, out_free, last_step;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_step = (r_cnt == CW'(TW - 1));

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = in_acc;
        o_cmd.div_start_t = in_acc;
        o_cmd.div_step    = (r_state == S_DIV_T) || (r_state == S_DIV_L);
        o_cmd.div_start_l = (r_state == S_SWAP);
        o_cmd.calc1       = (r_state == S_CALC1);
        o_cmd.calc2       = (r_state == S_CALC2);
        o_cmd.calc3       = (r_state == S_CALC3);
        o_cmd.calc4       = (r_state == S_CALC4);
        o_cmd.store       = (r_state == S_STORE) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = S_DIV_T;
            end
            S_DIV_T: begin
                n_cnt = r_cnt + 1'b1;
                if (last_step) n_state = S_SWAP;
            end
            S_SWAP: begin
                n_cnt   = '0;
                n_state = S_DIV_L;
            end
            S_DIV_L: begin
                n_cnt = r_cnt + 1'b1;
                if (last_step) n_state = S_CALC1;
            end
            S_CALC1: n_state = S_CALC2;
            S_CALC2: n_state = S_CALC3;
            S_CALC3: n_state = S_CALC4;
            S_CALC4: n_state = S_STORE;
            S_STORE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_T) && last_step |=> (r_state == S_SWAP))
        else $error("first remainder pass did not end after its bit count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |-> (!r_out_valid || !i_out_stall))
        else $error("result register written while a result is pending");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_STORE))
        else $error("result valid raised outside the store step");

    a_calc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC1) |-> ($past(r_state) == S_DIV_L))
        else $error("result math started without the second remainder pass");

endmodule

// ----- design/periodic_task_window_checker_top.sv -----
// Top level of the periodic task window checker: controller plus datapath.
// One request is taken at a time; its result is registered once both remainder
// passes over TW = min(TIME_BITS, 32) bits and the result steps are done, and the
// next request is taken the cycle after the result is registered. Both passes use
// a single bit-serial remainder unit, one quotient bit per cycle, that runs twice
// per request: once for the query time and once for the stored execution time,
// each modulo the period register. A result held in the output register does not
// block the next request; only a second result finishing before the first is
// taken waits. Configuration writes go straight to the registers and must only
// happen while no request is in flight.
module periodic_task_window_checker_top
    import ptwc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_res             o_out_data,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    t_cmd cmd;

    ptwc_ctrl #(
        .TIME_BITS(TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ptwc_datapath #(
        .TIME_BITS(TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

endmodule
